// ===== sv/sbr_pkg.sv =====
package sbr_pkg;

  localparam int VALUE_W = 11;
  localparam int SIZE_W  = 6;
  localparam int SIDE_W  = 7;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  localparam logic [1:0] CMD_ROTATE = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_RELOAD = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] row;
    logic [4:0] column;
    logic [3:0] radius;
    logic       direction;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] cell_value;
    logic               status;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_ROT,
    ST_EMIT
  } state_t;

endpackage

// ===== sv/square_block_rotator.sv =====
// Throughput: one request at a time, set by the single port of the cell memory,
// which every rotated cell passes through once for its read and once for its write.
// Reset (rst, synchronous): a numbering pass over every cell fills the cell
// memory; no request is taken until it ends.
module square_block_rotator #(
  parameter int MAX_SIDE = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [sbr_pkg::SIZE_W-1:0]   cfg_data,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  sbr_pkg::req_t                req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output sbr_pkg::rsp_t                rsp
);

  localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int VW    = sbr_pkg::VALUE_W;
  localparam int NW    = sbr_pkg::SIDE_W;
  localparam int RESET_SIDE = (int'(sbr_pkg::SIZE_RESET) > MAX_SIDE) ? MAX_SIDE :
                              int'(sbr_pkg::SIZE_RESET);

  logic [VW-1:0] mem [DEPTH];
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [VW-1:0] mem_wdata;
  logic [VW-1:0] mem_rdata;

  sbr_pkg::state_t state, state_next;

  logic [sbr_pkg::SIZE_W-1:0] size_reg;
  logic [NW-1:0]              n_now;
  logic [NW-1:0]              sweep_n;
  logic                       sweep_reply;
  logic [CW-1:0]              si, sj;
  logic [VW-1:0]              num;
  logic                       in_region;
  logic                       sweep_last;

  logic [4:0]    cx, cy;
  logic          dir;
  logic [3:0]    j;
  logic [4:0]    k;
  logic [2:0]    phase;
  logic [VW-1:0] v [4];
  sbr_pkg::rsp_t res;

  logic          fit_fail;
  logic          read_fail;
  logic          req_status;
  logic          k_last;
  logic          out_free;
  logic [1:0]    side;
  logic [NW-1:0] xm, xp, ym, yp;
  logic [NW-1:0] side_r, side_c;
  logic [AW-1:0] rot_addr;
  logic [AW-1:0] req_addr;
  logic [AW-1:0] sweep_addr;

  always_comb begin
    if (size_reg == '0) begin
      n_now = NW'(1);
    end else if (NW'(size_reg) > NW'(MAX_SIDE)) begin
      n_now = NW'(MAX_SIDE);
    end else begin
      n_now = NW'(size_reg);
    end
  end

  assign fit_fail  = (req.row < 5'(req.radius)) || (req.column < 5'(req.radius)) ||
                     (NW'(req.row) + NW'(req.radius) >= n_now) ||
                     (NW'(req.column) + NW'(req.radius) >= n_now);
  assign read_fail = (NW'(req.row) >= n_now) || (NW'(req.column) >= n_now);
  assign req_status = ((req.cmd == sbr_pkg::CMD_ROTATE) && fit_fail) ||
                      ((req.cmd == sbr_pkg::CMD_READ) && read_fail);

  assign k_last   = (k == 5'({j, 1'b0}) - 5'd1);
  assign out_free = !rsp_valid || rsp_ready;

  assign xm = NW'(cx) - NW'(j);
  assign xp = NW'(cx) + NW'(j);
  assign ym = NW'(cy) - NW'(j);
  assign yp = NW'(cy) + NW'(j);

  assign side = phase[2] ? (phase[1:0] + (dir ? 2'd3 : 2'd1)) : phase[1:0];

  always_comb begin
    case (side)
      2'd0: begin
        side_r = xm;
        side_c = ym + NW'(k);
      end
      2'd1: begin
        side_r = xm + NW'(k);
        side_c = yp;
      end
      2'd2: begin
        side_r = xp;
        side_c = yp - NW'(k);
      end
      default: begin
        side_r = xp - NW'(k);
        side_c = ym;
      end
    endcase
  end

  assign rot_addr   = AW'(CW'(side_r)) * AW'(MAX_SIDE) + AW'(CW'(side_c));
  assign req_addr   = AW'(CW'(req.row)) * AW'(MAX_SIDE) + AW'(CW'(req.column));
  assign sweep_addr = AW'(si) * AW'(MAX_SIDE) + AW'(sj);
  assign in_region  = (NW'(si) < sweep_n) && (NW'(sj) < sweep_n);
  assign sweep_last = (si == CW'(MAX_SIDE - 1)) && (sj == CW'(MAX_SIDE - 1));

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_addr   = rot_addr;
    mem_wdata  = v[phase[1:0]];
    case (state)
      sbr_pkg::ST_SWEEP: begin
        mem_addr  = sweep_addr;
        mem_we    = 1'b1;
        mem_wdata = in_region ? num + VW'(1) : '0;
        if (sweep_last) begin
          state_next = sweep_reply ? sbr_pkg::ST_EMIT : sbr_pkg::ST_IDLE;
        end
      end
      sbr_pkg::ST_IDLE: begin
        mem_addr = req_addr;
        if (req_valid) begin
          case (req.cmd)
            sbr_pkg::CMD_ROTATE: begin
              if (fit_fail || req.radius == '0) begin
                state_next = sbr_pkg::ST_EMIT;
              end else begin
                state_next = sbr_pkg::ST_ROT;
              end
            end
            sbr_pkg::CMD_READ: begin
              state_next = read_fail ? sbr_pkg::ST_EMIT : sbr_pkg::ST_READ;
            end
            sbr_pkg::CMD_RELOAD: begin
              state_next = sbr_pkg::ST_SWEEP;
            end
            default: begin
              state_next = sbr_pkg::ST_EMIT;
            end
          endcase
        end
      end
      sbr_pkg::ST_READ: begin
        state_next = sbr_pkg::ST_EMIT;
      end
      sbr_pkg::ST_ROT: begin
        mem_we = phase[2];
        if (phase == 3'd7 && k_last && j == 4'd1) begin
          state_next = sbr_pkg::ST_EMIT;
        end
      end
      sbr_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = sbr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sbr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbr_pkg::ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= sbr_pkg::SIZE_RESET;
    end else if (cfg_write) begin
      size_reg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      si          <= '0;
      sj          <= '0;
      num         <= '0;
      sweep_n     <= NW'(RESET_SIDE);
      sweep_reply <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (state == sbr_pkg::ST_EMIT && out_free) begin
        rsp_valid <= 1'b1;
        rsp       <= res;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        sbr_pkg::ST_SWEEP: begin
          if (in_region) begin
            num <= num + VW'(1);
          end
          if (sj == CW'(MAX_SIDE - 1)) begin
            sj <= '0;
            si <= si + CW'(1);
          end else begin
            sj <= sj + CW'(1);
          end
        end
        sbr_pkg::ST_IDLE: begin
          cx    <= req.row;
          cy    <= req.column;
          dir   <= req.direction;
          j     <= req.radius;
          k     <= '0;
          phase <= '0;
          res   <= {{VW{1'b0}}, req_status};
          if (req_valid && req.cmd == sbr_pkg::CMD_RELOAD) begin
            si          <= '0;
            sj          <= '0;
            num         <= '0;
            sweep_n     <= n_now;
            sweep_reply <= 1'b1;
          end
        end
        sbr_pkg::ST_READ: begin
          res.cell_value <= mem_rdata;
        end
        sbr_pkg::ST_ROT: begin
          if (phase inside {[3'd1:3'd4]}) begin
            v[2'(phase - 3'd1)] <= mem_rdata;
          end
          phase <= phase + 3'd1;
          if (phase == 3'd7) begin
            if (k_last) begin
              k <= '0;
              j <= j - 4'd1;
            end else begin
              k <= k + 5'd1;
            end
          end
        end
        default: begin
          res <= res;
        end
      endcase
    end
  end

  assign req_ready = (state == sbr_pkg::ST_IDLE);

endmodule

// ===== sv/sbr_checker.sv =====
module sbr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       cfg_write,
  input logic [sbr_pkg::SIZE_W-1:0] cfg_data,
  input logic                       req_valid,
  input logic                       req_ready,
  input sbr_pkg::req_t              req,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input sbr_pkg::rsp_t              rsp
);

  a_reset_no_rsp: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_reset_sweep: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request taken during numbering pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one is in work");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |-> rsp.cell_value == '0)
    else $error("failed request carries a cell value");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

endmodule

bind square_block_rotator sbr_checker u_sbr_checker (.*);
